### sv/igmp_gtr_pkg.sv
// Shared types, codes and constants for the IGMPv3 group table reporter.
package igmp_gtr_pkg;

   localparam int GROUP_SLOTS_DEFAULT = 16;
   localparam int PORTS_DEFAULT       = 2;

   localparam logic [2:0] RECORD_TYPE_RESET = 3'd2;
   localparam logic [7:0] REPORT_TYPE       = 8'h22;

   localparam logic [1:0] OP_JOIN   = 2'd0;
   localparam logic [1:0] OP_LEAVE  = 2'd1;
   localparam logic [1:0] OP_REPORT = 2'd2;

   localparam logic [2:0] ST_JOINED     = 3'd0;
   localparam logic [2:0] ST_ALREADY    = 3'd1;
   localparam logic [2:0] ST_FULL       = 3'd2;
   localparam logic [2:0] ST_LEFT       = 3'd3;
   localparam logic [2:0] ST_NOT_MEMBER = 3'd4;
   localparam logic [2:0] ST_REPORT     = 3'd5;
   localparam logic [2:0] ST_NO_GROUPS  = 3'd6;
   localparam logic [2:0] ST_ZERO_CSUM  = 3'd7;

   typedef struct packed {
      logic [1:0]  operation;
      logic        port_select;
      logic [31:0] group_address;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        word_valid;
      logic [31:0] message_word;
      logic        last;
   } rsp_item_type;

   typedef struct packed {
      logic        clear;
      logic        add;
      logic [15:0] op_a;
      logic [15:0] op_b;
   } csum_ctrl_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SEARCH_RD,
      S_SEARCH_CMP,
      S_MOVE_RD,
      S_MOVE_WR,
      S_APPEND,
      S_SUM_START,
      S_SUM_REC,
      S_SUM_GRP,
      S_SUM_CHECK,
      S_EMIT_HDR,
      S_EMIT_CNT,
      S_EMIT_REC,
      S_EMIT_GRP,
      S_RESP
   } state_type;

endpackage

### sv/igmp_gtr_table.sv
// Group table memory: one write port, one read port with registered data.
module igmp_gtr_table #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [31:0]   rd_data
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/igmp_gtr_csum.sv
// Ones' complement accumulator: adds two 16-bit halves per cycle while add is set, with end-around carry.
module igmp_gtr_csum (
   input  logic                        clock,
   input  igmp_gtr_pkg::csum_ctrl_type ctrl,
   output logic [15:0]                 sum
);

   import igmp_gtr_pkg::*;

   logic [15:0] acc_ff;
   logic [15:0] acc_in;
   logic [17:0] raw;
   logic [16:0] fold;

   always_comb begin
      raw    = {2'b00, (ctrl.clear ? 16'h0000 : acc_ff)} + {2'b00, ctrl.op_a}
               + {2'b00, ctrl.op_b};
      fold   = {1'b0, raw[15:0]} + {15'd0, raw[17:16]};
      acc_in = fold[15:0] + {15'd0, fold[16]};
   end

   always_ff @(posedge clock) begin
      if (ctrl.add) begin
         acc_ff <= acc_in;
      end
   end

   assign sum = acc_ff;

endmodule

### sv/igmp_group_table_reporter.sv
// Top level: IGMPv3 group tables per port with membership report sequencer.
//
// Input items arrive on req_valid/req_ready with a req_item struct holding the
// operation (join, leave, report), the port and the group address. Results
// leave on rsp_valid/rsp_ready as rsp_item structs; the item that ends an
// operation carries last. An unused operation code gives no result.
// req_ready is high only while the sequencer is idle; one item is worked on
// at a time. A join or leave scans the table one entry at a time through
// the single registered read port of the table memory. A report first runs
// the checksum: a start step, then the record word and group of each entry
// through the shared ones' complement adder, then a check step, then
// streams 2 + 2n words at one word per cycle while rsp_ready stays high.
// The output register holds a finished item while the receiver stalls, and
// the sequencer waits on it before loading the next word.
// csr_write_data sets the record type written into every record; write it
// only while the block is idle. Synchronous reset empties all tables, sets
// the record type to mode-is-exclude and drops any pending result.
module igmp_group_table_reporter #(
   parameter int GROUP_SLOTS = igmp_gtr_pkg::GROUP_SLOTS_DEFAULT,
   parameter int PORTS       = igmp_gtr_pkg::PORTS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  igmp_gtr_pkg::req_item_type req_item,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output igmp_gtr_pkg::rsp_item_type rsp_item,
   input  logic                       csr_write_enable,
   input  logic [2:0]                 csr_write_data
);

   import igmp_gtr_pkg::*;

   localparam int DEPTH = PORTS * GROUP_SLOTS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(GROUP_SLOTS + 1);
   localparam int PW    = (PORTS > 1) ? $clog2(PORTS) : 1;
   localparam logic [AW-1:0] SLOTS_A = AW'(GROUP_SLOTS);
   localparam logic [CW-1:0] SLOTS_C = CW'(GROUP_SLOTS);

   state_type     state_ff, state_in;
   logic [1:0]    op_ff, op_in;
   logic [PW-1:0] port_ff, port_in, port_req;
   logic [31:0]   addr_ff, addr_in;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [2:0]    status_ff, status_in;
   logic [2:0]    record_type_ff, record_type_in;
   logic [CW-1:0] count_ff [PORTS];
   logic [CW-1:0] count_in [PORTS];
   rsp_item_type  rsp_item_ff, rsp_item_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          out_free;
   logic          load;
   logic [CW-1:0] req_count;
   logic [CW-1:0] idx_next;
   logic          idx_end;
   logic [AW-1:0] base;
   logic [15:0]   csum_sum;
   logic [15:0]   checksum;
   logic [31:0]   rec_word;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [31:0]   wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [31:0]   rd_data;
   csum_ctrl_type csum_ctrl;

   igmp_gtr_table #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   igmp_gtr_csum u_csum (
      .clock (clock),
      .ctrl  (csum_ctrl),
      .sum   (csum_sum)
   );

   assign port_req  = (PORTS > 1) ? PW'(req_item.port_select) : '0;
   assign req_count = count_ff[port_req];
   assign idx_next  = idx_ff + CW'(1);
   assign idx_end   = (idx_next == n_ff);
   assign base      = AW'(port_ff) * SLOTS_A;
   assign checksum  = ~csum_sum;
   assign rec_word  = {5'd0, record_type_ff, 24'd0};
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         record_type_ff <= RECORD_TYPE_RESET;
         for (int p = 0; p < PORTS; p++) begin
            count_ff[p] <= '0;
         end
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         record_type_ff <= record_type_in;
         count_ff       <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      port_ff     <= port_in;
      addr_ff     <= addr_in;
      n_ff        <= n_in;
      idx_ff      <= idx_in;
      status_ff   <= status_in;
      rsp_item_ff <= rsp_item_in;
   end

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      port_in        = port_ff;
      addr_in        = addr_ff;
      n_in           = n_ff;
      idx_in         = idx_ff;
      status_in      = status_ff;
      count_in       = count_ff;
      record_type_in = csr_write_enable ? csr_write_data : record_type_ff;
      rsp_item_in    = rsp_item_ff;
      load           = 1'b0;
      req_ready      = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = base + AW'(idx_ff);
      wr_data        = rd_data;
      rd_en          = 1'b0;
      rd_addr        = base + AW'(idx_ff);
      csum_ctrl      = '{clear: 1'b0, add: 1'b0, op_a: 16'h0000, op_b: 16'h0000};

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in   = req_item.operation;
               port_in = port_req;
               addr_in = req_item.group_address;
               n_in    = req_count;
               idx_in  = '0;
               case (req_item.operation)
                  OP_JOIN: begin
                     if (req_count >= SLOTS_C) begin
                        status_in = ST_FULL;
                        state_in  = S_RESP;
                     end else if (req_count == '0) begin
                        state_in = S_APPEND;
                     end else begin
                        state_in = S_SEARCH_RD;
                     end
                  end
                  OP_LEAVE: begin
                     if (req_count == '0) begin
                        status_in = ST_NOT_MEMBER;
                        state_in  = S_RESP;
                     end else begin
                        state_in = S_SEARCH_RD;
                     end
                  end
                  OP_REPORT: begin
                     status_in = ST_REPORT;
                     state_in  = S_SUM_START;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_SEARCH_RD: begin
            rd_en    = 1'b1;
            state_in = S_SEARCH_CMP;
         end
         S_SEARCH_CMP: begin
            if (rd_data == addr_ff) begin
               if (op_ff == OP_JOIN) begin
                  status_in = ST_ALREADY;
                  state_in  = S_RESP;
               end else begin
                  state_in = S_MOVE_RD;
               end
            end else if (idx_end) begin
               if (op_ff == OP_JOIN) begin
                  state_in = S_APPEND;
               end else begin
                  status_in = ST_NOT_MEMBER;
                  state_in  = S_RESP;
               end
            end else begin
               idx_in   = idx_next;
               state_in = S_SEARCH_RD;
            end
         end
         S_MOVE_RD: begin
            rd_en    = 1'b1;
            rd_addr  = base + AW'(n_ff - CW'(1));
            state_in = S_MOVE_WR;
         end
         S_MOVE_WR: begin
            wr_en             = 1'b1;
            count_in[port_ff] = n_ff - CW'(1);
            status_in         = ST_LEFT;
            state_in          = S_RESP;
         end
         S_APPEND: begin
            wr_en             = 1'b1;
            wr_addr           = base + AW'(n_ff);
            wr_data           = addr_ff;
            count_in[port_ff] = n_ff + CW'(1);
            n_in              = n_ff + CW'(1);
            status_in         = ST_JOINED;
            state_in          = S_SUM_START;
         end
         S_SUM_START: begin
            idx_in = '0;
            if (n_ff == '0) begin
               status_in = ST_NO_GROUPS;
               state_in  = S_RESP;
            end else begin
               csum_ctrl = '{clear: 1'b1, add: 1'b1, op_a: {REPORT_TYPE, 8'h00},
                             op_b: 16'(n_ff)};
               state_in  = S_SUM_REC;
            end
         end
         S_SUM_REC: begin
            rd_en     = 1'b1;
            csum_ctrl = '{clear: 1'b0, add: 1'b1, op_a: rec_word[31:16], op_b: 16'h0000};
            state_in  = S_SUM_GRP;
         end
         S_SUM_GRP: begin
            csum_ctrl = '{clear: 1'b0, add: 1'b1, op_a: rd_data[31:16],
                          op_b: rd_data[15:0]};
            if (idx_end) begin
               state_in = S_SUM_CHECK;
            end else begin
               idx_in   = idx_next;
               state_in = S_SUM_REC;
            end
         end
         S_SUM_CHECK: begin
            idx_in = '0;
            if (checksum == 16'h0000) begin
               status_in = ST_ZERO_CSUM;
               state_in  = S_RESP;
            end else begin
               state_in = S_EMIT_HDR;
            end
         end
         S_EMIT_HDR: begin
            if (out_free) begin
               load        = 1'b1;
               rsp_item_in = '{status: status_ff, word_valid: 1'b1,
                               message_word: {REPORT_TYPE, 8'h00, checksum}, last: 1'b0};
               state_in    = S_EMIT_CNT;
            end
         end
         S_EMIT_CNT: begin
            if (out_free) begin
               load        = 1'b1;
               rsp_item_in = '{status: status_ff, word_valid: 1'b1,
                               message_word: 32'(n_ff), last: 1'b0};
               state_in    = S_EMIT_REC;
            end
         end
         S_EMIT_REC: begin
            if (out_free) begin
               load        = 1'b1;
               rd_en       = 1'b1;
               rsp_item_in = '{status: status_ff, word_valid: 1'b1,
                               message_word: rec_word, last: 1'b0};
               state_in    = S_EMIT_GRP;
            end
         end
         S_EMIT_GRP: begin
            if (out_free) begin
               load        = 1'b1;
               rsp_item_in = '{status: status_ff, word_valid: 1'b1,
                               message_word: rd_data, last: idx_end};
               if (idx_end) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_next;
                  state_in = S_EMIT_REC;
               end
            end
         end
         S_RESP: begin
            if (out_free) begin
               load        = 1'b1;
               rsp_item_in = '{status: status_ff, word_valid: 1'b0,
                               message_word: 32'd0, last: 1'b1};
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule
